FILE: src/assert_macros.svh
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define LRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/lrc_pkg.sv
package lrc_pkg;

  localparam int COORD_BITS = 24;
  localparam int DW         = COORD_BITS + 1;
  localparam int PW         = 2 * DW;
  localparam int NUM_MOVES  = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         delta_t;
  typedef logic [3:0]                   ocode_t;

  localparam ocode_t OC_NONE   = 4'b0000;
  localparam ocode_t OC_LEFT   = 4'b0001;
  localparam ocode_t OC_RIGHT  = 4'b0010;
  localparam ocode_t OC_BOTTOM = 4'b0100;
  localparam ocode_t OC_TOP    = 4'b1000;

  typedef enum logic [1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } reg_idx_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_t;

  typedef struct packed {
    logic   accepted;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } out_t;

  typedef struct packed {
    coord_t x_min;
    coord_t x_max;
    coord_t y_min;
    coord_t y_max;
  } rect_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    delta_t dx;
    delta_t dy;
    ocode_t c0;
    ocode_t c1;
    logic   done;
    logic   acc;
  } seg_t;

  typedef struct packed {
    seg_t            seg;
    logic            mv;
    logic            mv_end;
    logic            yedge;
    coord_t          edge_val;
    coord_t          base;
    logic            neg;
    logic            dz;
    logic [DW-1:0]   ud;
  } move_t;

  function automatic ocode_t outcode(coord_t x, coord_t y, rect_t r);
    ocode_t c;
    c = OC_NONE;
    if ($signed(x) < $signed(r.x_min)) c = c | OC_LEFT;
    else if ($signed(x) > $signed(r.x_max)) c = c | OC_RIGHT;
    if ($signed(y) < $signed(r.y_min)) c = c | OC_BOTTOM;
    else if ($signed(y) > $signed(r.y_max)) c = c | OC_TOP;
    return c;
  endfunction

endpackage

FILE: src/line_rect_clipper.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_t: start and end point
// out_     output     out_valid / out_stall out_t: accepted flag, clipped points
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// Fully pipelined: one segment may enter every cycle while in_stall is low.
// Between input and output lie the entry register, the four clip stages,
// each holding a one-bit-per-stage restoring divider of PW stages, and the
// output register. The whole pipeline freezes while a result waits under
// out_stall. Reset is synchronous and active low; it clears valid bits and
// the rectangle registers. Configuration writes are taken in any cycle.
module line_rect_clipper
  import lrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_t      in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_t     out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  reg_idx_t cfg_index,
  input  coord_t   cfg_wdata
);

  rect_t rect_r;
  logic  en;
  logic  out_vld_r;
  out_t  out_data_r;

  assign cfg_ready = 1'b1;
  assign en        = !(out_vld_r && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_MIN: rect_r.x_min <= cfg_wdata;
        REG_X_MAX: rect_r.x_max <= cfg_wdata;
        REG_Y_MIN: rect_r.y_min <= cfg_wdata;
        REG_Y_MAX: rect_r.y_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Entry stage: deltas and first outcodes.
  seg_t seg_in;

  always_comb begin
    seg_in.x0   = in_data.start_x;
    seg_in.y0   = in_data.start_y;
    seg_in.x1   = in_data.end_x;
    seg_in.y1   = in_data.end_y;
    seg_in.dx   = delta_t'(in_data.end_x) - delta_t'(in_data.start_x);
    seg_in.dy   = delta_t'(in_data.end_y) - delta_t'(in_data.start_y);
    seg_in.c0   = outcode(in_data.start_x, in_data.start_y, rect_r);
    seg_in.c1   = outcode(in_data.end_x, in_data.end_y, rect_r);
    seg_in.done = 1'b0;
    seg_in.acc  = 1'b0;
  end

  logic vld_s [NUM_MOVES+1];
  seg_t seg_s [NUM_MOVES+1];
  logic vld_0_r;
  seg_t seg_0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_0_r <= 1'b0;
    end else if (en) begin
      vld_0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_0_r <= seg_in;
    end
  end

  assign vld_s[0] = vld_0_r;
  assign seg_s[0] = seg_0_r;

  genvar m;
  generate
    for (m = 0; m < NUM_MOVES; m++) begin : g_move
      lrc_move u_move (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .rect    (rect_r),
        .in_vld  (vld_s[m]),
        .in_seg  (seg_s[m]),
        .out_vld (vld_s[m+1]),
        .out_seg (seg_s[m+1])
      );
    end
  endgenerate

  // After the last move an undecided segment is accepted only if both
  // endpoints now lie inside.
  seg_t fin;
  logic acc;
  out_t out_nxt;

  always_comb begin
    fin = seg_s[NUM_MOVES];
    acc = fin.done ? fin.acc : (fin.c0 == OC_NONE && fin.c1 == OC_NONE);
    out_nxt.accepted     = acc;
    out_nxt.clip_start_x = acc ? fin.x0 : '0;
    out_nxt.clip_start_y = acc ? fin.y0 : '0;
    out_nxt.clip_end_x   = acc ? fin.x1 : '0;
    out_nxt.clip_end_y   = acc ? fin.y1 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_s[NUM_MOVES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  logic [4*COORD_BITS-1:0] out_pts;

  assign out_pts = out_data[4*COORD_BITS-1:0];

`include "assert_macros.svh"

  `LRC_ASSERT(a_reject_zero, out_valid && !out_data.accepted |-> out_pts == '0, "rejected word has points")
  `LRC_ASSERT_ALWAYS(a_stall_cause, in_stall |-> out_valid && out_stall, "stall without held result")

endmodule

FILE: src/lrc_div.sv
module lrc_div
  import lrc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [PW-1:0] in_prod,
  input  move_t         in_side,
  output logic          out_vld,
  output logic [PW-1:0] out_q,
  output move_t         out_side
);

  // One quotient bit per stage: the dividend shifts out of the top of pq
  // while quotient bits shift in at the bottom.
  logic          vld_r  [PW];
  logic [DW-1:0] rem_r  [PW];
  logic [PW-1:0] pq_r   [PW];
  move_t         side_r [PW];

  genvar j;
  generate
    for (j = 0; j < PW; j++) begin : g_stage
      logic          vld_src;
      logic [DW-1:0] rem_src;
      logic [PW-1:0] pq_src;
      move_t         side_src;
      logic [DW:0]   r2;
      logic          ge;
      logic [DW:0]   diff;

      if (j == 0) begin : g_first
        assign vld_src  = in_vld;
        assign rem_src  = '0;
        assign pq_src   = in_prod;
        assign side_src = in_side;
      end else begin : g_next
        assign vld_src  = vld_r[j-1];
        assign rem_src  = rem_r[j-1];
        assign pq_src   = pq_r[j-1];
        assign side_src = side_r[j-1];
      end

      assign r2   = {rem_src, pq_src[PW-1]};
      assign ge   = r2 >= {1'b0, side_src.ud};
      assign diff = r2 - {1'b0, side_src.ud};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[j] <= 1'b0;
        end else if (en) begin
          vld_r[j] <= vld_src;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
          pq_r[j]   <= {pq_src[PW-2:0], ge};
          side_r[j] <= side_src;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[PW-1];
  assign out_q    = pq_r[PW-1];
  assign out_side = side_r[PW-1];

endmodule

FILE: src/lrc_move.sv
module lrc_move
  import lrc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  rect_t rect,
  input  logic  in_vld,
  input  seg_t  in_seg,
  output logic  out_vld,
  output seg_t  out_seg
);

  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  // Decide stage: settle accept or reject, otherwise pick the edge.
  seg_t   seg_a;
  logic   mv_a, mv_end_a, yedge_a;
  ocode_t co;
  delta_t a_a, b_a, d_a;
  coord_t edge_a, base_a;

  always_comb begin
    seg_a    = in_seg;
    mv_a     = 1'b0;
    mv_end_a = (in_seg.c0 == OC_NONE);
    co       = (in_seg.c0 != OC_NONE) ? in_seg.c0 : in_seg.c1;
    if (!in_seg.done) begin
      if (in_seg.c0 == OC_NONE && in_seg.c1 == OC_NONE) begin
        seg_a.done = 1'b1;
        seg_a.acc  = 1'b1;
      end else if ((in_seg.c0 & in_seg.c1) != OC_NONE) begin
        seg_a.done = 1'b1;
      end else begin
        mv_a = 1'b1;
      end
    end
    if ((co & OC_TOP) != OC_NONE) begin
      yedge_a = 1'b1;
      edge_a  = rect.y_max;
    end else if ((co & OC_BOTTOM) != OC_NONE) begin
      yedge_a = 1'b1;
      edge_a  = rect.y_min;
    end else if ((co & OC_RIGHT) != OC_NONE) begin
      yedge_a = 1'b0;
      edge_a  = rect.x_max;
    end else begin
      yedge_a = 1'b0;
      edge_a  = rect.x_min;
    end
    // On a horizontal edge x is computed from y; on a vertical one the reverse.
    if (yedge_a) begin
      a_a    = in_seg.dx;
      d_a    = in_seg.dy;
      base_a = in_seg.x0;
      b_a    = delta_t'(edge_a) - delta_t'(in_seg.y0);
    end else begin
      a_a    = in_seg.dy;
      d_a    = in_seg.dx;
      base_a = in_seg.y0;
      b_a    = delta_t'(edge_a) - delta_t'(in_seg.x0);
    end
  end

  logic   vld_b_r;
  move_t  side_b_r;
  delta_t a_b_r, b_b_r, d_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_b_r.seg      <= seg_a;
      side_b_r.mv       <= mv_a;
      side_b_r.mv_end   <= mv_end_a;
      side_b_r.yedge    <= yedge_a;
      side_b_r.edge_val <= edge_a;
      side_b_r.base     <= base_a;
      side_b_r.neg      <= 1'b0;
      side_b_r.dz       <= 1'b0;
      side_b_r.ud       <= '0;
      a_b_r             <= a_a;
      b_b_r             <= b_a;
      d_b_r             <= d_a;
    end
  end

  // Multiply stage on magnitudes.
  logic [DW-1:0] ua, ub;
  move_t         side_m;

  always_comb begin
    ua            = a_b_r[DW-1] ? DW'(-a_b_r) : DW'(a_b_r);
    ub            = b_b_r[DW-1] ? DW'(-b_b_r) : DW'(b_b_r);
    side_m        = side_b_r;
    side_m.ud     = d_b_r[DW-1] ? DW'(-d_b_r) : DW'(d_b_r);
    side_m.dz     = (d_b_r == '0);
    side_m.neg    = a_b_r[DW-1] ^ b_b_r[DW-1] ^ d_b_r[DW-1];
  end

  logic          vld_c_r;
  logic [PW-1:0] prod_c_r;
  move_t         side_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_c_r <= PW'(ua) * PW'(ub);
      side_c_r <= side_m;
    end
  end

  logic          vld_q;
  logic [PW-1:0] q;
  move_t         side_q;

  lrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_c_r),
    .in_prod  (prod_c_r),
    .in_side  (side_c_r),
    .out_vld  (vld_q),
    .out_q    (q),
    .out_side (side_q)
  );

  // Add the signed quotient to the base coordinate and saturate.
  logic signed [PW:0]   qs;
  logic signed [SW-1:0] sum;
  coord_t               sat;

  always_comb begin
    if (side_q.dz) qs = '0;
    else if (side_q.neg) qs = -$signed({1'b0, q});
    else qs = $signed({1'b0, q});
    sum = SW'(side_q.base) + SW'(qs);
    if (sum > SAT_HI) sat = coord_t'(SAT_HI);
    else if (sum < SAT_LO) sat = coord_t'(SAT_LO);
    else sat = coord_t'(sum);
  end

  logic   vld_d_r;
  move_t  side_d_r;
  coord_t sat_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else if (en) begin
      vld_d_r <= vld_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r <= side_q;
      sat_d_r  <= sat;
    end
  end

  // Write the new point back and recompute its outcode.
  seg_t   seg_nxt;
  coord_t nx, ny;

  always_comb begin
    seg_nxt = side_d_r.seg;
    nx      = side_d_r.yedge ? sat_d_r : side_d_r.edge_val;
    ny      = side_d_r.yedge ? side_d_r.edge_val : sat_d_r;
    if (side_d_r.mv) begin
      if (side_d_r.mv_end) begin
        seg_nxt.x1 = nx;
        seg_nxt.y1 = ny;
        seg_nxt.c1 = outcode(nx, ny, rect);
      end else begin
        seg_nxt.x0 = nx;
        seg_nxt.y0 = ny;
        seg_nxt.c0 = outcode(nx, ny, rect);
      end
    end
  end

  logic vld_e_r;
  seg_t seg_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
    end else if (en) begin
      vld_e_r <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_e_r <= seg_nxt;
    end
  end

  assign out_vld = vld_e_r;
  assign out_seg = seg_e_r;

endmodule
